/* design/bbvp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbvp_pkg
// Types and constants shared by the basic block vector profiler.
// ----------------------------------------------------------------------------
package bbvp_pkg;

  localparam int unsigned AddrW   = 64;
  localparam int unsigned InsnsW  = 10;
  localparam int unsigned IdentW  = 5;
  localparam int unsigned CountW  = 40;
  localparam int unsigned ValueW  = 48;
  localparam int unsigned TotalW  = 64;
  localparam int unsigned KindW   = 3;

  localparam logic [ValueW-1:0] IntervalReset = ValueW'(100000000);

  typedef enum logic {
    OP_TRANSLATE = 1'b0,
    OP_EXECUTE   = 1'b1
  } op_e;

  typedef enum logic [KindW-1:0] {
    KIND_NEW     = 3'd0,
    KIND_ENTRY   = 3'd1,
    KIND_END     = 3'd2,
    KIND_FULL    = 3'd3,
    KIND_UNKNOWN = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_INCR,
    CMD_ROTATE
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROC,
    ST_DUMP,
    ST_FINAL
  } state_e;

  typedef struct packed {
    logic              valid;
    logic [AddrW-1:0]  addr;
    logic [IdentW-1:0] ident;
    logic [InsnsW-1:0] insns;
    logic [CountW-1:0] count;
  } entry_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    cmd_e              cmd;
    logic [AddrW-1:0]  key;
    logic [IdentW-1:0] ident;
    logic [InsnsW-1:0] insns;
  } ctrl_t;

endpackage
`default_nettype wire

/* design/bbvp_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbvp_in_if
// Request channel carrying translate and execute events.
// ----------------------------------------------------------------------------
interface bbvp_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [63:0] block_address;
  logic [9:0]  block_insns;

  modport source (output valid, opcode, block_address, block_insns, input ready);
  modport sink   (input valid, opcode, block_address, block_insns, output ready);
endinterface
`default_nettype wire

/* design/bbvp_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbvp_out_if
// Result channel carrying profiler records.
// ----------------------------------------------------------------------------
interface bbvp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [4:0]  block_id;
  logic [63:0] address_out;
  logic [47:0] value;
  logic        last;

  modport source (output valid, kind, block_id, address_out, value, last, input ready);
  modport sink   (input valid, kind, block_id, address_out, value, last, output ready);
endinterface
`default_nettype wire

/* design/bbvp_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbvp_cell
// One table slot of the sorted chain: compare, insert shift, count, rotate.
// ----------------------------------------------------------------------------
module bbvp_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire bbvp_pkg::ctrl_t ctrl_i,
  input  wire bbvp_pkg::entry_t prev_i,
  input  wire logic            prev_gt_i,
  input  wire bbvp_pkg::entry_t next_i,
  output bbvp_pkg::entry_t     entry_o,
  output logic                 match_o,
  output logic                 gt_o
);
  import bbvp_pkg::*;

  entry_t entry_q, entry_d;

  assign match_o = entry_q.valid && (entry_q.addr == ctrl_i.key);
  // key belongs at or before this slot
  assign gt_o    = !entry_q.valid || (ctrl_i.key < entry_q.addr);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.cmd)
      CMD_INSERT: begin
        if (prev_gt_i) begin
          entry_d = prev_i;
        end else if (gt_o) begin
          entry_d.valid = 1'b1;
          entry_d.addr  = ctrl_i.key;
          entry_d.ident = ctrl_i.ident;
          entry_d.insns = ctrl_i.insns;
          entry_d.count = '0;
        end
      end
      CMD_INCR: begin
        if (match_o && (entry_q.count != {CountW{1'b1}})) begin
          entry_d.count = entry_q.count + CountW'(1);
        end
      end
      CMD_ROTATE: entry_d = next_i;
      default:    entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

endmodule
`default_nettype wire

/* design/basic_block_vector_profiler_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// basic_block_vector_profiler_core
// Basic block vector profiler: sorted chain of block cells with interval dumps.
// ----------------------------------------------------------------------------
// channel   dir  handshake        payload
// in_i      in   valid / ready    opcode, block_address, block_insns
// out_o     out  valid / ready    kind, block_id, address_out, value, last
// cfg       in   cfg_we_i         cfg_wdata_i (interval_length)
//
// a request is captured, then compared across all cells at once in ST_PROC.
// an interval dump walks the cell chain once in ST_DUMP, then sends the end
// record from ST_FINAL; each of these waits while the result register is stalled.
// reset clears all cells and loads the interval with 100000000.
// in_i.ready is high only while no request is in flight.
// ----------------------------------------------------------------------------
module basic_block_vector_profiler_core #(
  parameter int unsigned TABLE_ENTRIES = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [47:0] cfg_wdata_i,
  bbvp_in_if.sink          in_i,
  bbvp_out_if.source       out_o
);
  import bbvp_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);

  state_e state_q, state_d;
  logic [IdxW-1:0]   cnt_q, cnt_d;
  logic              op_q;
  logic [AddrW-1:0]  addr_q;
  logic [InsnsW-1:0] insns_q;
  logic              req_fire;

  logic [ValueW-1:0] interval_q;
  logic [TotalW-1:0] boundary_q, boundary_d;
  logic [TotalW-1:0] total_q, total_d, total_sum;
  logic [5:0]        next_id_q, next_id_d;

  logic              out_valid_q, out_valid_d;
  kind_e             out_kind_q, out_kind_d;
  logic [IdentW-1:0] out_id_q, out_id_d;
  logic [AddrW-1:0]  out_addr_q, out_addr_d;
  logic [ValueW-1:0] out_value_q, out_value_d;
  logic              out_last_q, out_last_d;
  logic              out_free;

  ctrl_t  ctrl;
  entry_t cell_data [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] cell_match, cell_gt, cell_valid;
  logic   hit, full;
  entry_t head;
  logic [ValueW+1:0] prod;

  assign req_fire = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || out_o.ready;

  // ---------------- cell chain ----------------
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    entry_t prev_e, next_e;
    logic   prev_gt;
    if (g == 0) begin : g_first
      assign prev_e  = '0;
      assign prev_gt = 1'b0;
    end else begin : g_mid
      assign prev_e  = cell_data[g-1];
      assign prev_gt = cell_gt[g-1];
    end
    if (g == TABLE_ENTRIES - 1) begin : g_wrap
      // head wraps to the tail with its count cleared
      always_comb begin
        next_e       = cell_data[0];
        next_e.count = '0;
      end
    end else begin : g_fwd
      assign next_e = cell_data[g+1];
    end
    bbvp_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .prev_i    (prev_e),
      .prev_gt_i (prev_gt),
      .next_i    (next_e),
      .entry_o   (cell_data[g]),
      .match_o   (cell_match[g]),
      .gt_o      (cell_gt[g])
    );
    assign cell_valid[g] = cell_data[g].valid;
  end

  assign hit  = |cell_match;
  assign full = cell_valid[TABLE_ENTRIES-1];
  assign head = cell_data[0];
  assign prod = (ValueW+2)'(head.count) * (ValueW+2)'(head.insns);
  assign total_sum = total_q + TotalW'(insns_q);

  // ---------------- control ----------------
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    boundary_d  = boundary_q;
    total_d     = total_q;
    next_id_d   = next_id_q;
    ctrl.cmd    = CMD_HOLD;
    ctrl.key    = addr_q;
    ctrl.ident  = next_id_q[IdentW-1:0];
    ctrl.insns  = insns_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_kind_d  = out_kind_q;
    out_id_d    = out_id_q;
    out_addr_d  = out_addr_q;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;

    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          state_d = ST_PROC;
        end
      end
      ST_PROC: begin
        if (out_free) begin
          state_d    = ST_IDLE;
          out_id_d   = '0;
          out_addr_d = addr_q;
          out_value_d = '0;
          out_last_d = 1'b1;
          if (op_q == OP_TRANSLATE) begin
            if (!hit) begin
              out_valid_d = 1'b1;
              if (full) begin
                out_kind_d = KIND_FULL;
              end else begin
                ctrl.cmd    = CMD_INSERT;
                out_kind_d  = KIND_NEW;
                out_id_d    = next_id_q[IdentW-1:0];
                out_value_d = ValueW'(insns_q);
                next_id_d   = next_id_q + 6'd1;
              end
            end
          end else if (!hit) begin
            out_valid_d = 1'b1;
            out_kind_d  = KIND_UNKNOWN;
          end else begin
            ctrl.cmd = CMD_INCR;
            total_d  = total_sum;
            if (total_sum >= boundary_q) begin
              boundary_d = boundary_q + TotalW'(interval_q);
              cnt_d      = '0;
              state_d    = ST_DUMP;
            end
          end
        end
      end
      ST_DUMP: begin
        if (!(head.valid && head.count != '0) || out_free) begin
          ctrl.cmd = CMD_ROTATE;
          cnt_d    = cnt_q + IdxW'(1);
          if (head.valid && head.count != '0) begin
            out_valid_d = 1'b1;
            out_kind_d  = KIND_ENTRY;
            out_id_d    = head.ident;
            out_addr_d  = head.addr;
            out_value_d = (|prod[ValueW+1:ValueW]) ? {ValueW{1'b1}} : prod[ValueW-1:0];
            out_last_d  = 1'b0;
          end
          if (cnt_q == IdxW'(TABLE_ENTRIES - 1)) begin
            state_d = ST_FINAL;
          end
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_END;
          out_id_d    = '0;
          out_addr_d  = '0;
          out_value_d = (|total_q[TotalW-1:ValueW]) ? {ValueW{1'b1}} : total_q[ValueW-1:0];
          out_last_d  = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (cfg_we_i) begin
      boundary_d = TotalW'(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      interval_q  <= IntervalReset;
      boundary_q  <= TotalW'(IntervalReset);
      total_q     <= '0;
      next_id_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      boundary_q  <= boundary_d;
      total_q     <= total_d;
      next_id_q   <= next_id_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        interval_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      op_q    <= in_i.opcode;
      addr_q  <= in_i.block_address;
      insns_q <= in_i.block_insns;
    end
    out_kind_q  <= out_kind_d;
    out_id_q    <= out_id_d;
    out_addr_q  <= out_addr_d;
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = out_kind_q;
  assign out_o.block_id    = out_id_q;
  assign out_o.address_out = out_addr_q;
  assign out_o.value       = out_value_q;
  assign out_o.last        = out_last_q;

  // ---------------- checks ----------------
  // only interval entries leave last low
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_last_q == (out_kind_q != KIND_ENTRY)))
    else $error("last flag does not match record kind");

  // occupied cells form a prefix of the chain between requests
  a_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> $onehot({1'b0, cell_valid} + (TABLE_ENTRIES+1)'(1)))
    else $error("cell chain has a hole");

  // a dump always closes with an end record
  a_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINAL && out_free) |=> (out_valid_q && out_kind_q == KIND_END))
    else $error("interval end record missing");

  // a dump starts only from an execute hit
  a_dump_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == ST_DUMP) |-> ($past(state_q) == ST_PROC && $past(op_q) == OP_EXECUTE))
    else $error("dump started without execute");

endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Profiler testbench: drives translate and execute requests under random
// idling on both channels and checks every record against a block table
// model kept in the scoreboard, across several interval settings.
// ----------------------------------------------------------------------------
module tb;
  import bbvp_pkg::*;

  localparam int Entries = 32;
  localparam logic [47:0] Max48 = 48'hFFFF_FFFF_FFFF;
  localparam logic [39:0] Max40 = 40'hFF_FFFF_FFFF;

  typedef struct {
    kind_e       kind;
    logic [4:0]  id;
    logic [63:0] addr;
    logic [47:0] val;
    logic        last;
  } record_t;

  class profile_board;
    record_t     due_q[$];
    int          errors;
    bit          used[Entries];
    logic [63:0] addr_tab[Entries];
    logic [4:0]  id_tab[Entries];
    logic [9:0]  insns_tab[Entries];
    logic [39:0] count_tab[Entries];
    logic [5:0]  ident_next;
    logic [63:0] total;
    logic [63:0] boundary;
    logic [47:0] interval;

    function new();
      errors = 0;
      foreach (used[i]) used[i] = 0;
      ident_next = 0;
      total = 0;
      interval = IntervalReset;
      boundary = {16'd0, IntervalReset};
    endfunction

    function void set_interval(logic [47:0] v);
      interval = v;
      boundary = {16'd0, v};
    endfunction

    function void push(kind_e k, logic [4:0] id, logic [63:0] a, logic [47:0] v,
                       logic l);
      record_t r;
      r.kind = k; r.id = id; r.addr = a; r.val = v; r.last = l;
      due_q.push_back(r);
    endfunction

    function void note_request(op_e op, logic [63:0] a, logic [9:0] n);
      int slot;
      int free;
      int best;
      bit have_prev;
      logic [63:0] prev;
      logic [63:0] prod;
      slot = -1;
      free = -1;
      for (int i = 0; i < Entries; i++) begin
        if (used[i] && addr_tab[i] == a) slot = i;
        if (!used[i] && free < 0) free = i;
      end
      if (op == OP_TRANSLATE) begin
        if (slot >= 0) return;
        if (free < 0) begin
          push(KIND_FULL, 0, a, 0, 1);
          return;
        end
        used[free] = 1;
        addr_tab[free] = a;
        id_tab[free] = ident_next[4:0];
        insns_tab[free] = n;
        count_tab[free] = 0;
        push(KIND_NEW, ident_next[4:0], a, {38'd0, n}, 1);
        ident_next = ident_next + 1;
        return;
      end
      if (slot < 0) begin
        push(KIND_UNKNOWN, 0, a, 0, 1);
        return;
      end
      if (count_tab[slot] != Max40) count_tab[slot]++;
      total = total + {54'd0, n};
      if (total < boundary) return;
      boundary = boundary + {16'd0, interval};
      // walk the table in ascending address order
      have_prev = 0;
      prev = 0;
      forever begin
        best = -1;
        for (int i = 0; i < Entries; i++) begin
          if (!used[i] || (have_prev && addr_tab[i] <= prev)) continue;
          if (best < 0 || addr_tab[i] < addr_tab[best]) best = i;
        end
        if (best < 0) break;
        have_prev = 1;
        prev = addr_tab[best];
        if (count_tab[best] != 0) begin
          prod = {24'd0, count_tab[best]} * {54'd0, insns_tab[best]};
          push(KIND_ENTRY, id_tab[best], addr_tab[best],
               (prod > {16'd0, Max48}) ? Max48 : prod[47:0], 0);
          count_tab[best] = 0;
        end
      end
      push(KIND_END, 0, 0, (total > {16'd0, Max48}) ? Max48 : total[47:0], 1);
    endfunction

    function void check_record(logic [2:0] k, logic [4:0] id, logic [63:0] a,
                               logic [47:0] v, logic l);
      record_t r;
      if (due_q.size() == 0) begin
        $error("unexpected record kind %0d addr %h", k, a);
        errors++;
        return;
      end
      r = due_q.pop_front();
      if (k !== r.kind) begin
        $error("kind expected %0d actual %0d", r.kind, k); errors++;
      end
      if (id !== r.id) begin
        $error("block_id expected %0d actual %0d", r.id, id); errors++;
      end
      if (a !== r.addr) begin
        $error("address_out expected %h actual %h", r.addr, a); errors++;
      end
      if (v !== r.val) begin
        $error("value expected %0d actual %0d", r.val, v); errors++;
      end
      if (l !== r.last) begin
        $error("last expected %0d actual %0d", r.last, l); errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [47:0] cfg_wdata_i;
  bbvp_in_if   req_ch ();
  bbvp_out_if  rec_ch ();

  basic_block_vector_profiler_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (req_ch),
    .out_o      (rec_ch)
  );

  profile_board board;
  int           idle_in;
  int           idle_out;
  logic         hold_req;
  bit           hold_taken;
  int           hold_left;
  logic [63:0]  addr_pool[40];
  int           sent;

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  initial begin
    #10ms;
    $display("FAIL");
    $finish;
  end

  // result side: checks accepted records and paces ready
  initial begin
    rec_ch.ready <= 1'b0;
    hold_taken = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rec_ch.valid && rec_ch.ready)
        board.check_record(rec_ch.kind, rec_ch.block_id, rec_ch.address_out,
                           rec_ch.value, rec_ch.last);
      if (hold_req && !hold_taken) begin
        hold_taken = 1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        rec_ch.ready <= 1'b0;
      end else begin
        rec_ch.ready <= rst_ni && ($urandom_range(99) >= idle_out);
      end
    end
  end

  task automatic send_request(op_e op, logic [63:0] a, logic [9:0] n);
    idle_in = (sent < 160) ? 33 : (sent < 320) ? 64 : 0;
    idle_out = (sent < 160) ? 64 : (sent < 320) ? 33 : 0;
    while ($urandom_range(99) < idle_in) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.opcode <= op;
    req_ch.block_address <= a;
    req_ch.block_insns <= n;
    do @(posedge clk_i); while (!req_ch.ready);
    board.note_request(op, a, n);
    sent++;
  endtask

  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (board.due_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_interval(logic [47:0] v);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_interval(v);
  endtask

  task automatic random_request();
    int pick;
    logic [63:0] a;
    op_e op;
    pick = $urandom_range(99);
    a = addr_pool[$urandom_range(39)];
    op = (pick < 70) ? OP_EXECUTE : OP_TRANSLATE;
    if (pick >= 90) begin
      a = {$urandom, $urandom};
      op = op_e'($urandom_range(1));
    end
    send_request(op, a, 10'($urandom_range(512, 1)));
  endtask

  initial begin
    logic [47:0] phase_len[6];
    int          phase_items[6];
    board = new();
    sent = 0;
    idle_in = 33;
    idle_out = 64;
    hold_req <= 1'b0;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    req_ch.valid <= 1'b0;
    req_ch.opcode <= OP_TRANSLATE;
    req_ch.block_address <= '0;
    req_ch.block_insns <= 10'd1;
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int i = 2; i < 40; i++) addr_pool[i] = {$urandom, $urandom};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, known and unknown blocks, then tiny and maximal intervals
    send_request(OP_TRANSLATE, 64'd0, 10'd1);
    send_request(OP_TRANSLATE, '1, 10'd512);
    send_request(OP_TRANSLATE, 64'd0, 10'd77);
    send_request(OP_EXECUTE, 64'd0, 10'd5);
    send_request(OP_EXECUTE, '1, 10'd512);
    send_request(OP_EXECUTE, 64'h5555_AAAA_5555_AAAA, 10'd3);
    send_request(OP_TRANSLATE, 64'h8000_0000_0000_0000, 10'd255);
    send_request(OP_TRANSLATE, 64'h0000_0000_0000_0001, 10'd256);
    write_interval(48'd1);
    send_request(OP_EXECUTE, 64'd0, 10'd1);
    send_request(OP_EXECUTE, '1, 10'd2);
    send_request(OP_EXECUTE, 64'h8000_0000_0000_0000, 10'd9);
    write_interval(48'd0);
    send_request(OP_EXECUTE, 64'h0000_0000_0000_0001, 10'd1);
    send_request(OP_EXECUTE, 64'd0, 10'd511);
    write_interval(Max48);
    send_request(OP_EXECUTE, '1, 10'd512);

    phase_len = '{48'd1, 48'd0, 48'd2000, Max48, 48'd300, 48'd1};
    phase_items = '{40, 40, 100, 100, 100, 100};
    for (int p = 0; p < 6; p++) begin
      write_interval(phase_len[p]);
      for (int i = 0; i < phase_items[p]; i++) begin
        if (p == 0 && i == 10) hold_req <= 1'b1;
        random_request();
      end
    end

    wait_idle();
    repeat (50) @(posedge clk_i);
    if (board.errors == 0 && board.due_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
design/bbvp_pkg.sv
design/bbvp_in_if.sv
design/bbvp_out_if.sv
design/bbvp_cell.sv
design/basic_block_vector_profiler_core.sv
tb/tb.sv
